// ===== rtl/wfds_pkg.sv =====
// ----------------------------------------------------------------------------
// wfds_pkg
// Shared types, constants and codes of the weighted fair dispatch scheduler.
// ----------------------------------------------------------------------------
package wfds_pkg;

  localparam int MAX_TASKS     = 16;
  localparam int IDX_W         = $clog2(MAX_TASKS);
  localparam int FRACTION_BITS = 16;
  localparam int VR_W          = 48;
  localparam int DIV_W         = 8 + FRACTION_BITS;

  localparam logic [7:0]      SLICE_RESET = 8'd5;
  localparam logic [VR_W-1:0] VR_MAX      = {VR_W{1'b1}};

  localparam logic OP_ADMIT    = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [2:0] {
    ST_ADMITTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_RAN      = 3'd2,
    ST_IDLE     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_WAIT,
    S_SCAN,
    S_DIVIDE,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic op;
    logic [15:0] task_id;
    logic [31:0] arrival_time;
    logic [15:0] burst_length;
    logic [15:0] ticket_weight;
  } req_t;

  typedef struct packed {
    status_t status;
    logic [15:0] run_id;
    logic [31:0] slice_start;
    logic [31:0] slice_end;
    logic [15:0] left_to_run;
    logic finished;
    logic [31:0] wait_total;
    logic [31:0] turnaround;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, reset scan
    logic admit;     // write the admit entry and form its result
    logic scan_step; // examine one entry
    logic div_start; // set up the divider on the pick
    logic div_step;  // one quotient bit
    logic finish;    // commit dispatch result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic scan_last;
    logic div_last;
    logic any_valid;
    logic have_pick;
  } sts_t;

endpackage

// ===== rtl/wfds_if.sv =====
// ----------------------------------------------------------------------------
// wfds_req_if / wfds_rsp_if
// Valid/ready channels of the scheduler.
// ----------------------------------------------------------------------------
interface wfds_req_if;
  logic valid;
  logic ready;
  logic op;
  logic [15:0] task_id;
  logic [31:0] arrival_time;
  logic [15:0] burst_length;
  logic [15:0] ticket_weight;
  modport source (output valid, op, task_id, arrival_time, burst_length, ticket_weight,
                  input ready);
  modport sink (input valid, op, task_id, arrival_time, burst_length, ticket_weight,
                output ready);
endinterface

interface wfds_rsp_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [15:0] run_id;
  logic [31:0] slice_start;
  logic [31:0] slice_end;
  logic [15:0] left_to_run;
  logic finished;
  logic [31:0] wait_total;
  logic [31:0] turnaround;
  modport source (output valid, status, run_id, slice_start, slice_end, left_to_run,
                  finished, wait_total, turnaround, input ready);
  modport sink (input valid, status, run_id, slice_start, slice_end, left_to_run,
                finished, wait_total, turnaround, output ready);
endinterface

// ===== rtl/wfds_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfds_ctrl
// Sequencer: accept, table scan, vruntime divide, commit, result hold.
// ----------------------------------------------------------------------------
module wfds_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  wfds_pkg::sts_t  sts,
  output wfds_pkg::cmd_t  cmd
);

  wfds_pkg::state_t state, state_next;
  logic div_first;

  always_ff @(posedge clk) begin
    if (rst) state <= wfds_pkg::S_WAIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      wfds_pkg::S_WAIT: begin
        if (in_valid) state_next = wfds_pkg::S_SCAN;
      end
      wfds_pkg::S_SCAN: begin
        if (sts.op == wfds_pkg::OP_ADMIT) state_next = wfds_pkg::S_OUT;
        else if (sts.scan_last) state_next = wfds_pkg::S_DIVIDE;
      end
      wfds_pkg::S_DIVIDE: begin
        // the bit counter is stale during the setup cycle
        if (!sts.any_valid || !sts.have_pick || (sts.div_last && !div_first))
          state_next = wfds_pkg::S_FINISH;
      end
      wfds_pkg::S_FINISH: state_next = wfds_pkg::S_OUT;
      wfds_pkg::S_OUT: begin
        if (out_ready) state_next = wfds_pkg::S_WAIT;
      end
      default: state_next = wfds_pkg::S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) div_first <= 1'b0;
    else     div_first <= (state == wfds_pkg::S_SCAN) && sts.scan_last;
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      wfds_pkg::S_WAIT: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      wfds_pkg::S_SCAN: begin
        cmd.admit     = (sts.op == wfds_pkg::OP_ADMIT);
        cmd.scan_step = (sts.op == wfds_pkg::OP_DISPATCH);
      end
      wfds_pkg::S_DIVIDE: begin
        cmd.div_start = div_first;
        cmd.div_step  = !div_first;
      end
      wfds_pkg::S_FINISH: cmd.finish = 1'b1;
      wfds_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/wfds_dp.sv =====
// ----------------------------------------------------------------------------
// wfds_dp
// Task table, sequential minimum search, restoring divider and result register.
// ----------------------------------------------------------------------------
module wfds_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  input  wfds_pkg::req_t  req,
  input  wfds_pkg::cmd_t  cmd,
  output wfds_pkg::sts_t  sts,
  output wfds_pkg::rsp_t  rsp
);

  localparam int N  = wfds_pkg::MAX_TASKS;
  localparam int IW = wfds_pkg::IDX_W;
  localparam int DW = wfds_pkg::DIV_W;
  localparam int VW = wfds_pkg::VR_W;

  logic [N-1:0]  valid;
  logic [15:0]   e_id     [N];
  logic [31:0]   e_arr    [N];
  logic [15:0]   e_burst  [N];
  logic [15:0]   e_left   [N];
  logic [15:0]   e_weight [N];
  logic [VW-1:0] e_vr     [N];

  logic [7:0]    slice_cfg;
  logic [31:0]   now;
  wfds_pkg::req_t r;

  logic [IW-1:0] scan_idx;
  logic [IW-1:0] pick;
  logic          have_pick;
  logic          any_valid;

  logic [DW-1:0] dividend;
  logic [15:0]   divisor;
  logic [16:0]   rem;
  logic [DW-1:0] quo;
  logic [$clog2(DW+1)-1:0] div_cnt;
  logic [7:0]    run;

  // lowest free entry for admits
  logic          free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  logic better;
  always_comb begin
    better = !have_pick || (e_vr[scan_idx] < e_vr[pick]) ||
             ((e_vr[scan_idx] == e_vr[pick]) && (e_id[scan_idx] < e_id[pick]));
  end

  logic [7:0]  ts_eff;
  logic [15:0] pl;
  always_comb begin
    ts_eff = (slice_cfg == 8'd0) ? 8'd1 : slice_cfg;
    pl     = e_left[pick];
  end

  logic [16:0] rem_sh;
  always_comb rem_sh = {rem[15:0], dividend[DW-1]};

  // commit arithmetic
  logic [32:0] end_sum;
  logic [31:0] end_t;
  logic [31:0] now_inc;
  logic [15:0] left_new;
  logic [VW:0] vr_sum;
  logic [32:0] elapsed;
  logic [16:0] ran_t;
  always_comb begin
    end_sum  = {1'b0, now} + 33'(run);
    end_t    = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
    now_inc  = (now == 32'hFFFF_FFFF) ? now : now + 32'd1;
    left_new = pl - 16'(run);
    vr_sum   = {1'b0, e_vr[pick]} + (VW + 1)'(quo);
    elapsed  = {1'b0, end_t} - {1'b0, e_arr[pick]};
    ran_t    = {1'b0, e_burst[pick]} - {1'b0, left_new};
  end

  // result words for admit and dispatch
  wfds_pkg::rsp_t rsp_adm;
  wfds_pkg::rsp_t rsp_fin;
  always_comb begin
    rsp_adm = '0;
    if (free_found) rsp_adm.status = wfds_pkg::ST_ADMITTED;
    else            rsp_adm.status = wfds_pkg::ST_FULL;
    rsp_fin = '0;
    if (!any_valid) rsp_fin.status = wfds_pkg::ST_EMPTY;
    else if (!have_pick) begin
      rsp_fin.status      = wfds_pkg::ST_IDLE;
      rsp_fin.slice_start = now;
      rsp_fin.slice_end   = now_inc;
    end else begin
      rsp_fin.status      = wfds_pkg::ST_RAN;
      rsp_fin.run_id      = e_id[pick];
      rsp_fin.slice_start = now;
      rsp_fin.slice_end   = end_t;
      rsp_fin.left_to_run = left_new;
      rsp_fin.wait_total  = (elapsed > {16'd0, ran_t}) ?
                            32'(elapsed - {16'd0, ran_t}) : 32'd0;
      if (left_new == 16'd0) begin
        rsp_fin.finished   = 1'b1;
        rsp_fin.turnaround = elapsed[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      slice_cfg <= wfds_pkg::SLICE_RESET;
      now       <= '0;
    end else begin
      if (cfg_we) slice_cfg <= cfg_data;
      if (cmd.admit && free_found) valid[free_idx] <= 1'b1;
      if (cmd.finish && any_valid) begin
        if (!have_pick) now <= now_inc;
        else begin
          now <= end_t;
          if (left_new == 16'd0) valid[pick] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r         <= req;
      scan_idx  <= '0;
      have_pick <= 1'b0;
      any_valid <= 1'b0;
      pick      <= '0;
    end
    if (cmd.admit) begin
      rsp <= rsp_adm;
      if (free_found) begin
        e_id[free_idx]     <= r.task_id;
        e_arr[free_idx]    <= r.arrival_time;
        e_burst[free_idx]  <= r.burst_length;
        e_left[free_idx]   <= r.burst_length;
        e_weight[free_idx] <= (r.ticket_weight == 16'd0) ? 16'd1 : r.ticket_weight;
        e_vr[free_idx]     <= '0;
      end
    end
    if (cmd.scan_step) begin
      scan_idx <= scan_idx + IW'(1);
      if (valid[scan_idx]) begin
        any_valid <= 1'b1;
        if (e_arr[scan_idx] <= now && better) begin
          pick      <= scan_idx;
          have_pick <= 1'b1;
        end
      end
    end
    if (cmd.div_start) begin
      run      <= (pl < {8'd0, ts_eff}) ? pl[7:0] : ts_eff;
      dividend <= {((pl < {8'd0, ts_eff}) ? pl[7:0] : ts_eff),
                   {wfds_pkg::FRACTION_BITS{1'b0}}};
      divisor  <= e_weight[pick];
      rem      <= '0;
      quo      <= '0;
      div_cnt  <= '0;
    end
    if (cmd.div_step) begin
      // restoring division, one quotient bit per cycle
      dividend <= {dividend[DW-2:0], 1'b0};
      div_cnt  <= div_cnt + 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_sh - {1'b0, divisor};
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      rsp <= rsp_fin;
      if (any_valid && have_pick) begin
        e_left[pick] <= left_new;
        e_vr[pick]   <= vr_sum[VW] ? wfds_pkg::VR_MAX : vr_sum[VW-1:0];
      end
    end
  end

  always_comb begin
    sts.op        = r.op;
    sts.scan_last = (scan_idx == IW'(N - 1));
    sts.div_last  = (div_cnt == ($bits(div_cnt))'(DW - 1));
    sts.any_valid = any_valid;
    sts.have_pick = have_pick;
  end

endmodule

// ===== rtl/weighted_fair_dispatch_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_fair_dispatch_scheduler_unit
// Virtual-runtime fair scheduler over a 16-entry task table.
// ----------------------------------------------------------------------------
// One request at a time. An admit passes from the scan state straight to the
// result state. A dispatch scans the table one entry per cycle, sets up a
// restoring divider, forms the vruntime increment at one quotient bit per
// cycle and then commits; with an empty table or no arrived task the divide
// is skipped after its setup. The next request is accepted the cycle after
// the result is taken, and output stalls delay that accept directly.
module weighted_fair_dispatch_scheduler_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  wfds_req_if.sink      req,
  wfds_rsp_if.source    rsp
);

  wfds_pkg::cmd_t cmd;
  wfds_pkg::sts_t sts;
  wfds_pkg::req_t req_d;
  wfds_pkg::rsp_t rsp_d;

  always_comb begin
    req_d.op            = req.op;
    req_d.task_id       = req.task_id;
    req_d.arrival_time  = req.arrival_time;
    req_d.burst_length  = req.burst_length;
    req_d.ticket_weight = req.ticket_weight;
  end

  assign rsp.status      = rsp_d.status;
  assign rsp.run_id      = rsp_d.run_id;
  assign rsp.slice_start = rsp_d.slice_start;
  assign rsp.slice_end   = rsp_d.slice_end;
  assign rsp.left_to_run = rsp_d.left_to_run;
  assign rsp.finished    = rsp_d.finished;
  assign rsp.wait_total  = rsp_d.wait_total;
  assign rsp.turnaround  = rsp_d.turnaround;

  wfds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wfds_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .req     (req_d),
    .cmd     (cmd),
    .sts     (sts),
    .rsp     (rsp_d)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("accept while result pending");
  a_finish_ran: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.finished |->
      rsp.status == wfds_pkg::ST_RAN && rsp.left_to_run == 16'd0)
    else $error("finished without a run");
  a_rsp_after: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ready |=> req.ready) else $error("no return to accept");
`endif

endmodule

// ===== dv/weighted_fair_dispatch_scheduler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// weighted_fair_dispatch_scheduler_unit_tb
// Drives admit and dispatch requests into the scheduler with random gaps and
// stalls, predicts each result from a behavioral task table and checks every
// field in order. Time slice is varied between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module weighted_fair_dispatch_scheduler_unit_tb;

  localparam int LIMIT_CYCLES = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  wfds_req_if req ();
  wfds_rsp_if rsp ();

  weighted_fair_dispatch_scheduler_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req.sink),
    .rsp      (rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler state mirror
  logic        tbl_valid [wfds_pkg::MAX_TASKS];
  logic [15:0] tbl_id [wfds_pkg::MAX_TASKS];
  logic [31:0] tbl_arrival [wfds_pkg::MAX_TASKS];
  logic [15:0] tbl_burst [wfds_pkg::MAX_TASKS];
  logic [15:0] tbl_left [wfds_pkg::MAX_TASKS];
  logic [15:0] tbl_weight [wfds_pkg::MAX_TASKS];
  logic [wfds_pkg::VR_W-1:0] tbl_vrun [wfds_pkg::MAX_TASKS];
  logic [31:0] sched_clock;
  logic [7:0]  slice_reg;

  wfds_pkg::req_t pending_reqs[$];
  wfds_pkg::rsp_t expected_rsps[$];

  int   cycle_cnt = 0;
  int   mismatch_cnt = 0;
  int   rsp_cnt = 0;
  int   n_ran = 0, n_idle = 0, n_full = 0, n_empty = 0;
  bit   calm = 0;
  bit   hold_go = 0;
  bit   hold_done = 0;
  int   hold_len = 0;

  function automatic logic [31:0] clock_plus(logic [31:0] t, logic [31:0] d);
    logic [32:0] s;
    s = {1'b0, t} + {1'b0, d};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic wfds_pkg::rsp_t schedule_step(wfds_pkg::req_t r);
    wfds_pkg::rsp_t o;
    int pick;
    bit any;
    logic [15:0] ts, run;
    logic [48:0] vsum;
    logic [47:0] inc;
    logic [32:0] elapsed, ran;
    o = '0;
    pick = -1;
    any = 0;
    if (r.op == wfds_pkg::OP_ADMIT) begin
      for (int i = 0; i < wfds_pkg::MAX_TASKS; i++) begin
        if (!tbl_valid[i]) begin
          tbl_valid[i] = 1'b1;
          tbl_id[i] = r.task_id;
          tbl_arrival[i] = r.arrival_time;
          tbl_burst[i] = r.burst_length;
          tbl_left[i] = r.burst_length;
          tbl_weight[i] = (r.ticket_weight == 0) ? 16'd1 : r.ticket_weight;
          tbl_vrun[i] = '0;
          o.status = wfds_pkg::ST_ADMITTED;
          return o;
        end
      end
      o.status = wfds_pkg::ST_FULL;
      return o;
    end
    for (int i = 0; i < wfds_pkg::MAX_TASKS; i++) begin
      if (tbl_valid[i]) begin
        any = 1;
        if (tbl_arrival[i] <= sched_clock) begin
          if (pick < 0 || tbl_vrun[i] < tbl_vrun[pick] ||
              (tbl_vrun[i] == tbl_vrun[pick] && tbl_id[i] < tbl_id[pick]))
            pick = i;
        end
      end
    end
    if (!any) begin
      o.status = wfds_pkg::ST_EMPTY;
      return o;
    end
    if (pick < 0) begin
      o.status = wfds_pkg::ST_IDLE;
      o.slice_start = sched_clock;
      sched_clock = clock_plus(sched_clock, 1);
      o.slice_end = sched_clock;
      return o;
    end
    ts = (slice_reg == 0) ? 16'd1 : {8'd0, slice_reg};
    run = (tbl_left[pick] < ts) ? tbl_left[pick] : ts;
    o.status = wfds_pkg::ST_RAN;
    o.run_id = tbl_id[pick];
    o.slice_start = sched_clock;
    sched_clock = clock_plus(sched_clock, {16'd0, run});
    o.slice_end = sched_clock;
    inc = ({32'd0, run} << wfds_pkg::FRACTION_BITS) / tbl_weight[pick];
    vsum = {1'b0, tbl_vrun[pick]} + {1'b0, inc};
    tbl_vrun[pick] = vsum[48] ? wfds_pkg::VR_MAX : vsum[47:0];
    tbl_left[pick] = tbl_left[pick] - run;
    elapsed = {1'b0, sched_clock} - {1'b0, tbl_arrival[pick]};
    ran = {17'd0, tbl_burst[pick] - tbl_left[pick]};
    o.left_to_run = tbl_left[pick];
    o.wait_total = (elapsed > ran) ? 32'(elapsed - ran) : 32'd0;
    if (tbl_left[pick] == 0) begin
      o.finished = 1'b1;
      o.turnaround = elapsed[31:0];
      tbl_valid[pick] = 1'b0;
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
        wfds_pkg::req_t r;
        r = pending_reqs.pop_front();
        req.valid <= 1'b1;
        req.op <= r.op;
        req.task_id <= r.task_id;
        req.arrival_time <= r.arrival_time;
        req.burst_length <= r.burst_length;
        req.ticket_weight <= r.ticket_weight;
        expected_rsps = {expected_rsps, schedule_step(r)};
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // receiver stalls; long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      rsp.ready <= 1'b0;
      hold_len <= hold_len + 1;
      if (hold_len >= 400) hold_done <= 1'b1;
    end else begin
      rsp.ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      wfds_pkg::rsp_t e;
      rsp_cnt <= rsp_cnt + 1;
      if (expected_rsps.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected result, status %0d", rsp.status);
      end else begin
        e = expected_rsps.pop_front();
        case (e.status)
          wfds_pkg::ST_RAN: n_ran <= n_ran + 1;
          wfds_pkg::ST_IDLE: n_idle <= n_idle + 1;
          wfds_pkg::ST_FULL: n_full <= n_full + 1;
          wfds_pkg::ST_EMPTY: n_empty <= n_empty + 1;
          default: ;
        endcase
        if (rsp.status !== e.status || rsp.run_id !== e.run_id ||
            rsp.slice_start !== e.slice_start || rsp.slice_end !== e.slice_end ||
            rsp.left_to_run !== e.left_to_run || rsp.finished !== e.finished ||
            rsp.wait_total !== e.wait_total || rsp.turnaround !== e.turnaround) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("mismatch: exp st=%0d id=%0h s=%0h e=%0h l=%0h f=%0b w=%0h t=%0h",
                     e.status, e.run_id, e.slice_start, e.slice_end, e.left_to_run,
                     e.finished, e.wait_total, e.turnaround, "\n",
                     "          got st=%0d id=%0h s=%0h e=%0h l=%0h f=%0b w=%0h t=%0h",
                     rsp.status, rsp.run_id, rsp.slice_start, rsp.slice_end,
                     rsp.left_to_run, rsp.finished, rsp.wait_total, rsp.turnaround);
        end
      end
    end
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("weighted_fair_dispatch_scheduler_unit test failed");
      $finish;
    end
  end

  task automatic add_req(logic op, logic [15:0] id, logic [31:0] arr,
                         logic [15:0] burst, logic [15:0] wt);
    wfds_pkg::req_t r;
    r.op = op;
    r.task_id = id;
    r.arrival_time = arr;
    r.burst_length = burst;
    r.ticket_weight = wt;
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic drain_and_config(logic [7:0] val);
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (expected_rsps.size() != 0 || req.valid) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_reg = val;
  endtask

  // well-formed burst: admits in arrival order, then dispatches
  task automatic task_set(int n, int nd, bit wide);
    logic [31:0] arr;
    arr = sched_clock + $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      arr = clock_plus(arr, $urandom_range(0, 8));
      add_req(wfds_pkg::OP_ADMIT, 16'($urandom_range(0, 7)), arr,
              wide ? 16'($urandom) : 16'($urandom_range(0, 20)),
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)));
    end
    for (int k = 0; k < nd; k++)
      add_req(wfds_pkg::OP_DISPATCH, 16'($urandom), $urandom, 16'($urandom),
              16'($urandom));
  endtask

  initial begin
    int sent;
    int n_adm, n_dsp;
    logic [7:0] slices [5];
    slices = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd17};
    slice_reg = wfds_pkg::SLICE_RESET;
    sched_clock = '0;
    for (int i = 0; i < wfds_pkg::MAX_TASKS; i++) tbl_valid[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty, idle tick, zero burst, duplicate ids
    add_req(wfds_pkg::OP_DISPATCH, 16'hFFFF, '1, '1, '1);
    add_req(wfds_pkg::OP_ADMIT, 16'hFFFF, 32'd3, 16'hFFFF, 16'hFFFF);
    add_req(wfds_pkg::OP_DISPATCH, '0, '0, '0, '0);
    add_req(wfds_pkg::OP_ADMIT, 16'd7, 32'd0, 16'd0, 16'd0);
    add_req(wfds_pkg::OP_ADMIT, 16'd7, 32'd0, 16'd4, 16'd0);
    add_req(wfds_pkg::OP_ADMIT, 16'd7, 32'd0, 16'd4, 16'd2);
    for (int k = 0; k < 6; k++) add_req(wfds_pkg::OP_DISPATCH, '0, '0, '0, '0);
    for (int k = 0; k < 14; k++) add_req(wfds_pkg::OP_ADMIT, 16'(k), 32'd2, 16'd1, 16'd1);
    sent = 26;
    drain_and_config(8'd0);
    for (int k = 0; k < 18; k++) add_req(wfds_pkg::OP_DISPATCH, '0, '0, '0, '0);
    sent += 18;

    // long receiver hold-off while requests keep coming
    drain_and_config(8'd4);
    hold_go = 1'b1;
    task_set(6, 10, 0);
    sent += 16;

    // late arrival: an admit near the top of the time range, then dispatches
    drain_and_config(8'd255);
    add_req(wfds_pkg::OP_ADMIT, 16'd1, 32'hFFFF_FF00, 16'hFFFF, 16'd0);
    for (int k = 0; k < 12; k++) add_req(wfds_pkg::OP_DISPATCH, '0, '0, '0, '0);
    sent += 13;

    // random phases over several slice settings
    for (int p = 0; p < 5; p++) begin
      drain_and_config(slices[p]);
      // the drain above lets all outstanding requests finish before the slice changes
      calm = (p == 2);
      while (sent < 150 + p * 175) begin
        if ($urandom_range(9) < 8) begin
          n_adm = $urandom_range(1, 6);
          n_dsp = $urandom_range(2, 14);
          task_set(n_adm, n_dsp, $urandom_range(9) == 0);
          sent += n_adm + n_dsp;
        end else begin
          add_req(1'($urandom), 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
          sent++;
        end
      end
    end
    calm = 0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (expected_rsps.size() != 0 || req.valid) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d results checked: %0d slices run, %0d idle ticks, %0d full, %0d empty",
             rsp_cnt, n_ran, n_idle, n_full, n_empty);
    $display("slice settings 0, 1, 3, 4, 5, 17 and 255 used; %0d mismatches", mismatch_cnt);
    if (mismatch_cnt == 0)
      $display("weighted_fair_dispatch_scheduler_unit test passed");
    else
      $display("weighted_fair_dispatch_scheduler_unit test failed");
    $finish;
  end

endmodule
